>>> hdl/oscillator_with_adsr_envelope_defines.svh
// assertion macros for the oscillator with adsr envelope
`ifndef OSCILLATOR_WITH_ADSR_ENVELOPE_DEFINES_SVH
`define OSCILLATOR_WITH_ADSR_ENVELOPE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define OAWE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oawe check failed");

// next-cycle implication, sampled on clk, off during reset
`define OAWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oawe check failed");

`else

`define OAWE_ASSERT_IMPL(label, ante, cons)
`define OAWE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/oawe_pkg.sv
// shared types, codes and table functions of the oscillator with adsr envelope
package oawe_pkg;

    typedef enum logic [2:0] {
        ST_ATTACK  = 3'd0,
        ST_DECAY   = 3'd1,
        ST_SUSTAIN = 3'd2,
        ST_RELEASE = 3'd3,
        ST_OFF     = 3'd4
    } env_stage_t;

    typedef enum logic [2:0] {
        REG_WAVEFORM        = 3'd0,
        REG_OSC_AMPLITUDE   = 3'd1,
        REG_PHASE_INCREMENT = 3'd2,
        REG_ENVELOPE_ENABLE = 3'd3,
        REG_ATTACK_STEP     = 3'd4,
        REG_DECAY_STEP      = 3'd5,
        REG_HOLD_LEVEL      = 3'd6,
        REG_RELEASE_STEP    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    // microcode step addresses
    typedef enum logic [2:0] {
        STEP_ENV      = 3'd0,
        STEP_MUL_WAVE = 3'd1,
        STEP_WAVE     = 3'd2,
        STEP_MUL_ENV  = 3'd3,
        STEP_S_PROD   = 3'd4,
        STEP_S_WAVE   = 3'd5,
        STEP_OUT      = 3'd6
    } step_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_WAVE = 2'd1,
        MUL_ENV  = 2'd2
    } mul_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT    = 2'd0,
        JMP_ALWAYS  = 2'd1,
        JMP_ENV_OFF = 2'd2,
        JMP_DONE    = 2'd3
    } jump_t;

    typedef struct packed {
        logic     env_upd;
        logic     phase_adv;
        mul_sel_t mul_sel;
        logic     ld_wave;
        logic     ld_s_prod;
        logic     ld_s_wave;
        logic     ld_out;
        jump_t    jump;
        step_t    target;
    } ucode_t;

    localparam int STEP_W  = 25;
    localparam int SAMPLE_W = 18;
    localparam int SINE_W  = 17;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // envelope settings handed to the envelope unit
    typedef struct packed {
        logic [STEP_W-1:0] attack_step;
        logic [STEP_W-1:0] decay_step;
        logic [STEP_W-1:0] hold_level;
        logic [STEP_W-1:0] release_step;
    } env_cfg_t;

    // envelope result seen at the output
    typedef struct packed {
        env_stage_t        stage;
        logic [STEP_W-1:0] value;
    } env_view_t;

    // quarter-wave sine in q15 by truncated taylor series, used for rom contents only
    function automatic logic signed [SINE_W-1:0] quarter_sine(input logic [63:0] k,
                                                              input int table_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] r;
        longint      sum;
        x   = (HALF_PI_Q30 * k) >> (table_bits - 2);
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        for (int n = 0; n < 5; n++)
        begin
            p = (t * x2) >> 30;
            case (n)
                0:       t = p / 6;
                1:       t = p / 20;
                2:       t = p / 42;
                3:       t = p / 72;
                default: t = p / 110;
            endcase
            if (n % 2 == 1)
                sum = sum + longint'(t);
            else
                sum = sum - longint'(t);
        end
        if (sum < 0)
            sum = 0;
        r = (64'(sum) + 64'd16384) >> 15;
        if (r > 64'd32768)
            r = 64'd32768;
        return SINE_W'(r);
    endfunction

    // full-turn sine entry from quarter symmetry
    function automatic logic signed [SINE_W-1:0] sine_entry(input logic [63:0] idx,
                                                            input int table_bits);
        logic [63:0] qlen;
        logic [63:0] quad;
        logic [63:0] r;
        logic signed [SINE_W-1:0] v;
        qlen = 64'd1 << (table_bits - 2);
        quad = (idx >> (table_bits - 2)) & 64'd3;
        r    = idx & (qlen - 64'd1);
        v    = quarter_sine(quad[0] ? (qlen - r) : r, table_bits);
        return quad[1] ? -v : v;
    endfunction

endpackage

>>> hdl/oawe_env.sv
// adsr envelope stage and level register with its per-tick update
module oawe_env #(
    parameter int LEVEL_FRAC_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                upd,
    input  logic                                key_on,
    input  logic                                key_off,
    input  oawe_pkg::env_cfg_t                  cfg,
    output logic [LEVEL_FRAC_BITS:0]            level,
    output oawe_pkg::env_view_t                 view
);
    import oawe_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int EW = ((LW > STEP_W) ? LW : STEP_W) + 1;
    localparam logic [EW-1:0] ONE_E = EW'(1) << LEVEL_FRAC_BITS;

    env_stage_t      stage_reg;
    env_stage_t      stage_next;
    env_stage_t      stage_in;
    logic [LW-1:0]   level_reg;
    logic [LW-1:0]   level_next;
    logic [EW-1:0]   lvl_e;
    logic [EW-1:0]   sus_raw;
    logic [EW-1:0]   sus_e;
    logic [EW-1:0]   att_sum;
    logic [EW-1:0]   dec_lim;
    logic [EW-1:0]   rel_e;
    logic [EW-1:0]   dec_e;

    always_comb
    begin
        lvl_e   = EW'(level_reg);
        sus_raw = EW'(cfg.hold_level);
        sus_e   = (sus_raw > ONE_E) ? ONE_E : sus_raw;
        dec_e   = EW'(cfg.decay_step);
        rel_e   = EW'(cfg.release_step);
        att_sum = lvl_e + EW'(cfg.attack_step);
        dec_lim = sus_e + dec_e;

        if (key_on)
            stage_in = ST_ATTACK;
        else if (key_off && stage_reg != ST_OFF)
            stage_in = ST_RELEASE;
        else
            stage_in = stage_reg;

        stage_next = stage_in;
        level_next = level_reg;
        case (stage_in)
            ST_ATTACK:
            begin
                if (att_sum >= ONE_E)
                begin
                    level_next = LW'(ONE_E);
                    stage_next = ST_DECAY;
                end
                else
                    level_next = LW'(att_sum);
            end
            ST_DECAY:
            begin
                if (lvl_e <= dec_lim)
                begin
                    level_next = LW'(sus_e);
                    stage_next = ST_SUSTAIN;
                end
                else
                    level_next = LW'(lvl_e - dec_e);
            end
            ST_RELEASE:
            begin
                if (lvl_e <= rel_e)
                begin
                    level_next = '0;
                    stage_next = ST_OFF;
                end
                else
                    level_next = LW'(lvl_e - rel_e);
            end
            ST_SUSTAIN:
                stage_next = ST_SUSTAIN;
            default:
                stage_next = ST_OFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_OFF;
            level_reg <= '0;
        end
        else if (upd)
        begin
            stage_reg <= stage_next;
            level_reg <= level_next;
        end
    end

    assign level      = level_reg;
    assign view.stage = stage_reg;
    assign view.value = STEP_W'(lvl_e);

endmodule

>>> hdl/oscillator_with_adsr_envelope.sv
// top level: microcoded phase-accumulator oscillator with adsr envelope
//
// One input transfer is one sample tick carrying key_on and key_off; it yields
// one output transfer with the 8-bit sample, the envelope stage and the
// envelope level after this tick's update. Each tick runs a seven-word
// microprogram over one shared 18 x 26 signed multiplier: envelope update and
// sine rom read, wave product, wave select, envelope product, shift, and the
// clamp and byte mapping; with the envelope disabled it skips the envelope product
// and its shift and takes the selected wave as it is. The steps follow the chain of
// dependent products through the single shared multiplier, in order. One tick
// is in work at a time, and the next is accepted as soon as the program has
// loaded the output register, even while that result still waits. Settings
// are written through the cfg channel, which is always ready, and should be
// changed only while no tick is in work. The sine rom holds 2^SINE_TABLE_BITS
// entries built at elaboration and is read through a registered port.
`include "oscillator_with_adsr_envelope_defines.svh"

module oscillator_with_adsr_envelope #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int LEVEL_FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // input tick stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] key_on, [1] key_off, [7:2] zero
    // output sample stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] sample_byte, [10:8] envelope_stage,
                                   // [35:11] envelope_value, [39:36] zero
    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import oawe_pkg::*;

    localparam int LW       = LEVEL_FRAC_BITS + 1;
    localparam int MULA_W   = SAMPLE_W;
    localparam int MULB_W   = (LW + 1 > SINE_W) ? LW + 1 : SINE_W;
    localparam int PROD_W   = MULA_W + MULB_W;
    localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;
    localparam logic [LW:0] LEVEL_ONE = (LW + 1)'(1) << LEVEL_FRAC_BITS;

    typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_DEPTH; i++)
            rom[i] = sine_entry(64'(i), SINE_TABLE_BITS);
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // microprogram, one control word per step
    function automatic ucode_t ucode_word(input step_t s);
        ucode_t u;
        u = '{env_upd: 1'b0, phase_adv: 1'b0, mul_sel: MUL_NONE, ld_wave: 1'b0,
              ld_s_prod: 1'b0, ld_s_wave: 1'b0, ld_out: 1'b0, jump: JMP_NEXT,
              target: STEP_ENV};
        case (s)
            STEP_ENV:
            begin
                u.env_upd   = 1'b1;
                u.phase_adv = 1'b1;
            end
            STEP_MUL_WAVE:
                u.mul_sel = MUL_WAVE;
            STEP_WAVE:
            begin
                u.ld_wave = 1'b1;
                u.jump    = JMP_ENV_OFF;
                u.target  = STEP_S_WAVE;
            end
            STEP_MUL_ENV:
                u.mul_sel = MUL_ENV;
            STEP_S_PROD:
            begin
                u.ld_s_prod = 1'b1;
                u.jump      = JMP_ALWAYS;
                u.target    = STEP_OUT;
            end
            STEP_S_WAVE:
                u.ld_s_wave = 1'b1;
            STEP_OUT:
            begin
                u.ld_out = 1'b1;
                u.jump   = JMP_DONE;
            end
            default:
                u.jump = JMP_DONE;
        endcase
        return u;
    endfunction

    // settings
    wave_t             waveform_reg;
    logic [15:0]       amplitude_reg;
    logic [31:0]       phase_inc_reg;
    logic              env_en_reg;
    env_cfg_t          env_cfg_reg;

    // sequencer
    logic              busy_reg;
    logic              busy_next;
    step_t             step_reg;
    step_t             step_next;
    ucode_t            uc;
    logic              stall;
    logic              fire;
    logic              accept;

    // datapath
    logic [PHASE_BITS-1:0]       phase_reg;
    logic                        key_on_reg;
    logic                        key_off_reg;
    logic [15:0]                 f_reg;
    logic signed [SINE_W-1:0]    sine_q_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [SAMPLE_W-1:0]  w_reg;
    logic signed [SAMPLE_W-1:0]  s_reg;
    logic signed [MULA_W-1:0]    mul_a;
    logic signed [MULB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [MULA_W-1:0]    wave_v;
    logic signed [SAMPLE_W-1:0]  wave_sel;
    logic signed [SINE_W-1:0]    s_clamp;
    logic signed [24:0]          byte_acc;
    logic [LW-1:0]               env_level;
    env_view_t                   env_view;

    // output register
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [7:0]        byte_reg;
    env_view_t         view_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg  <= WAVE_SINE;
            amplitude_reg <= '0;
            phase_inc_reg <= '0;
            env_en_reg    <= 1'b0;
            env_cfg_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_WAVEFORM:        waveform_reg              <= wave_t'(cfg_data[1:0]);
                REG_OSC_AMPLITUDE:   amplitude_reg             <= cfg_data[15:0];
                REG_PHASE_INCREMENT: phase_inc_reg             <= cfg_data;
                REG_ENVELOPE_ENABLE: env_en_reg                <= cfg_data[0];
                REG_ATTACK_STEP:     env_cfg_reg.attack_step   <= cfg_data[STEP_W-1:0];
                REG_DECAY_STEP:      env_cfg_reg.decay_step    <= cfg_data[STEP_W-1:0];
                REG_HOLD_LEVEL:      env_cfg_reg.hold_level    <= cfg_data[STEP_W-1:0];
                REG_RELEASE_STEP:    env_cfg_reg.release_step  <= cfg_data[STEP_W-1:0];
                default:             env_en_reg                <= env_en_reg;
            endcase
        end
    end

    // sequencer: step counter with conditional jumps
    always_comb
    begin
        uc    = ucode_word(step_reg);
        stall = uc.ld_out && m_tvalid_reg && !m_tready;   // output slot still full
        fire  = busy_reg && !stall;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = STEP_ENV;
        end
        else if (fire)
        begin
            case (uc.jump)
                JMP_NEXT:    step_next = step_t'(step_reg + 3'd1);
                JMP_ALWAYS:  step_next = uc.target;
                JMP_ENV_OFF: step_next = env_en_reg ? step_t'(step_reg + 3'd1) : uc.target;
                JMP_DONE:
                begin
                    busy_next = 1'b0;
                    step_next = STEP_ENV;
                end
                default:
                begin
                    busy_next = 1'b0;
                    step_next = STEP_ENV;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_ENV;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // capture of the tick's keys
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_on_reg  <= s_tdata[0];
            key_off_reg <= s_tdata[1];
        end
    end

    oawe_env #(
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_env (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (fire && uc.env_upd),
        .key_on  (key_on_reg),
        .key_off (key_off_reg),
        .cfg     (env_cfg_reg),
        .level   (env_level),
        .view    (env_view)
    );

    // phase accumulator, sampled before the advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (fire && uc.phase_adv)
            phase_reg <= phase_reg + PHASE_BITS'(phase_inc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (fire && uc.phase_adv)
        begin
            f_reg      <= phase_reg[PHASE_BITS-1 -: 16];
            sine_q_reg <= SINE_ROM[phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]];
        end
    end

    // saw and triangle ramps before amplitude scaling
    always_comb
    begin
        if (waveform_reg == WAVE_SAW)
            wave_v = $signed({2'b00, f_reg}) - 18'sd32768;
        else if (!f_reg[15])
            wave_v = $signed({1'b0, f_reg, 1'b0}) - 18'sd32768;
        else
            wave_v = 18'sd98304 - $signed({1'b0, f_reg, 1'b0});
    end

    // shared multiplier operand select
    always_comb
    begin
        case (uc.mul_sel)
            MUL_WAVE:
            begin
                mul_a = wave_v;
                mul_b = $signed(MULB_W'(amplitude_reg));
            end
            MUL_ENV:
            begin
                mul_a = w_reg;
                mul_b = $signed(MULB_W'(env_level));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        // full-width signed product
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (fire && uc.mul_sel != MUL_NONE)
            prod_reg <= mul_p;
    end

    // wave select; floor shifts are arithmetic shifts
    always_comb
    begin
        case (waveform_reg)
            WAVE_SINE:   wave_sel = SAMPLE_W'(sine_q_reg);
            WAVE_SQUARE: wave_sel = f_reg[15] ? 18'sd0 : 18'sd32768;
            default:     wave_sel = SAMPLE_W'(prod_reg >>> 15);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fire && uc.ld_wave)
            w_reg <= wave_sel;
        if (fire && uc.ld_s_prod)
            s_reg <= SAMPLE_W'(prod_reg >>> LEVEL_FRAC_BITS);
        else if (fire && uc.ld_s_wave)
            s_reg <= w_reg;
    end

    // clamp to one and map to a byte
    always_comb
    begin
        if (s_reg > 18'sd32768)
            s_clamp = 17'sd32767 + 17'sd1;
        else if (s_reg < -18'sd32768)
            s_clamp = -17'sd32767 - 17'sd1;
        else
            s_clamp = SINE_W'(s_reg);
        byte_acc = 25'(s_clamp) * 25'sd127 + 25'sd4194304;
    end

    // output register
    always_comb
    begin
        if (fire && uc.ld_out)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && uc.ld_out)
        begin
            byte_reg <= byte_acc[22:15];
            view_reg <= env_view;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, view_reg.value, view_reg.stage, byte_reg};

    // a transfer in always starts the program at its first step
    `OAWE_ASSERT_NEXT(a_start_step, accept, busy_reg && step_reg == STEP_ENV)
    // the envelope level never climbs past one
    `OAWE_ASSERT_IMPL(a_level_max, 1'b1, (LW + 1)'(env_level) <= LEVEL_ONE)
    // a new result only appears after the output step ran
    `OAWE_ASSERT_IMPL(a_out_from_step, $rose(m_tvalid_reg),
                      $past(busy_reg) && $past(step_reg) == STEP_OUT)

endmodule
